/* src/gps_binary_frame_parser_core_defines.svh */
// assertion macros shared by the checker
`ifndef GPS_BINARY_FRAME_PARSER_CORE_DEFINES_SVH
`define GPS_BINARY_FRAME_PARSER_CORE_DEFINES_SVH

// checked only outside reset
`define GBFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define GBFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/gbfp_pkg.sv */
`default_nettype none
package gbfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hD0;
  localparam logic [7:0] SYNC_SECOND = 8'hDD;
  localparam logic [7:0] FIX_3D_CODE = 8'h03;

  localparam int REC_BYTES    = 32;
  localparam int REC_W        = 8 * REC_BYTES;
  localparam int POS_W        = $clog2(REC_BYTES) + 1;
  localparam int FIX_KIND_POS = 21;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CKB   = 3'd4
  } phase_t;

  // byte held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_stage_t;

  // decoded frame leaving the parser
  typedef struct packed {
    logic             valid;
    logic             frame_ok;
    logic             fix_3d;
    logic [REC_W-1:0] rec;
  } frame_res_t;

endpackage
`default_nettype wire

/* src/gbfp_in_reg.sv */
`default_nettype none
module gbfp_in_reg
  import gbfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        adv,
  output byte_stage_t      stage
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;

  // the held byte moves on whenever the output side has room
  assign in_tready = !valid_r || adv;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
    end
  end

  assign stage.valid = valid_r;
  assign stage.data  = data_r;

endmodule
`default_nettype wire

/* src/gbfp_parser.sv */
`default_nettype none
module gbfp_parser
  import gbfp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire byte_stage_t stage,
  input  wire logic  adv,
  output frame_res_t res
);

  phase_t           phase_r;
  phase_t           phase_nxt;
  logic [7:0]       left_r;
  logic [7:0]       left_nxt;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [7:0]       sum_a_r;
  logic [7:0]       sum_a_nxt;
  logic [7:0]       sum_b_r;
  logic [7:0]       sum_b_nxt;
  logic [7:0]       chk_a_r;
  logic [7:0]       chk_a_nxt;
  logic [7:0]       rec_r [REC_BYTES];
  logic             wr_en;
  logic [REC_W-1:0] rec_flat;
  logic             go;
  logic [7:0]       b;

  assign go = stage.valid && adv;
  assign b  = stage.data;

  always_comb begin
    phase_nxt = phase_r;
    if (go) begin
      unique case (phase_r)
        PH_SYNC2: phase_nxt = (b == SYNC_SECOND) ? PH_LEN : PH_HUNT;
        PH_LEN:   phase_nxt = PH_DATA;
        PH_DATA:  phase_nxt = (left_r != 8'd0) ? PH_DATA : PH_CKB;
        PH_CKB:   phase_nxt = PH_HUNT;
        default:  phase_nxt = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < REC_BYTES; i++) begin
      rec_flat[8*i +: 8] = rec_r[i];
    end
  end

  always_comb begin
    left_nxt     = left_r;
    pos_nxt      = pos_r;
    sum_a_nxt    = sum_a_r;
    sum_b_nxt    = sum_b_r;
    chk_a_nxt    = chk_a_r;
    wr_en        = 1'b0;
    res.valid    = 1'b0;
    res.frame_ok = (chk_a_r == sum_a_r) && (b == sum_b_r);
    res.fix_3d   = (rec_r[FIX_KIND_POS] == FIX_3D_CODE);
    res.rec      = rec_flat;
    if (go) begin
      unique case (phase_r)
        PH_SYNC2: begin
          if (b == SYNC_SECOND) begin
            pos_nxt = '0;
          end
        end
        PH_LEN: begin
          left_nxt  = b;
          sum_a_nxt = b;
          sum_b_nxt = b;
        end
        PH_DATA: begin
          if (left_r != 8'd0) begin
            // bytes past the record end are summed only
            if (!pos_r[POS_W-1]) begin
              wr_en   = 1'b1;
              pos_nxt = pos_r + POS_W'(1);
            end
            left_nxt  = left_r - 8'd1;
            sum_a_nxt = sum_a_r + b;
            sum_b_nxt = sum_b_r + sum_a_r + b;
          end else begin
            chk_a_nxt = b;
          end
        end
        PH_CKB: begin
          res.valid = 1'b1;
        end
        default: begin
          res.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      left_r  <= '0;
      pos_r   <= '0;
      sum_a_r <= '0;
      sum_b_r <= '0;
      chk_a_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      chk_a_r <= chk_a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REC_BYTES; i++) begin
        rec_r[i] <= '0;
      end
    end else if (wr_en) begin
      rec_r[pos_r[POS_W-2:0]] <= b;
    end
  end

endmodule
`default_nettype wire

/* src/gbfp_out_reg.sv */
`default_nettype none
module gbfp_out_reg
  import gbfp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire frame_res_t        res,
  output logic                   adv,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [REC_W-1:0]       out_tdata,
  output logic [1:0]             out_tuser
);

  logic             valid_r;
  logic             valid_nxt;
  logic [REC_W-1:0] data_r;
  logic [1:0]       user_r;

  assign adv = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (adv) begin
      valid_nxt = res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      data_r <= res.rec;
      user_r <= {res.fix_3d, res.frame_ok};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule
`default_nettype wire

/* src/gps_binary_frame_parser_core.sv */
// result path: final check byte -> input register -> parser step -> output register
// throughput: one byte per cycle unless the output register is stalled, through the
// combinational parser step between the input register and the output register
// reset: synchronous active-low rst_n returns to sync hunting, clears sums,
// counters and the 32-byte record, and empties both registers
`default_nettype none
module gps_binary_frame_parser_core
  import gbfp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] rx_byte
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // [31:0] latitude, [63:32] longitude, [95:64] altitude, [127:96] ground_speed,
  // [159:128] course, [167:160] satellites, [175:168] fix_kind,
  // [207:176] date_word, [239:208] time_word, [255:240] hdop_raw
  output logic [REC_W-1:0]       out_tdata,
  output logic [1:0]             out_tuser   // [0] frame_ok, [1] fix_3d
);

  byte_stage_t stage;
  frame_res_t  res;
  logic        adv;

  gbfp_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .adv       (adv),
    .stage     (stage)
  );

  gbfp_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .stage (stage),
    .adv   (adv),
    .res   (res)
  );

  gbfp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

/* src/gbfp_checker.sv */
`default_nettype none
`include "gps_binary_frame_parser_core_defines.svh"
module gbfp_checker
  import gbfp_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic [7:0]       in_tdata,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [REC_W-1:0] out_tdata,
  input wire logic [1:0]       out_tuser
);

  // no frame can leave straight out of reset
  `GBFP_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")
  // with the output empty the input side must never stall
  `GBFP_ASSERT(a_ready_when_empty, !out_tvalid |-> in_tready, "input stalled with empty output")
  // a waiting input item keeps its byte
  `GBFP_ASSERT(a_in_hold, in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata), "waiting item changed")
  // a held result keeps its payload
  `GBFP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind gps_binary_frame_parser_core gbfp_checker u_gbfp_checker (.*);
`default_nettype wire

/* sim/gps_binary_frame_parser_core_tb.sv */
module gps_binary_frame_parser_core_tb
  import gbfp_pkg::*;
;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int DIR_ROWS     = 22;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic [7:0]       in_tdata   = 8'h00;
  logic             out_tready = 1'b0;
  logic             in_tready;
  logic             out_tvalid;
  logic [REC_W-1:0] out_tdata;
  logic [1:0]       out_tuser;

  always #1 clk = ~clk;

  gps_binary_frame_parser_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  typedef struct {
    logic               frame_ok;
    logic               fix_3d;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic signed [31:0] altitude;
    logic [31:0]        ground_speed;
    logic [31:0]        course;
    logic [7:0]         satellites;
    logic [7:0]         fix_kind;
    logic [31:0]        date_word;
    logic [31:0]        time_word;
    logic [15:0]        hdop_raw;
  } gps_frame_t;

  // directed row: typed rows carry a frame result that is all-zero record plus flags
  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    logic       ok;
    logic       fix;
  } dir_row_t;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // zero-length frame straight after reset
    '{SYNC_FIRST, 1'b0, 1'b0, 1'b0}, '{SYNC_SECOND, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b1, 1'b0},
    // sync broken by a second 0xd0, then 0xdd while hunting
    '{SYNC_FIRST, 1'b0, 1'b0, 1'b0}, '{SYNC_FIRST, 1'b0, 1'b0, 1'b0},
    '{SYNC_SECOND, 1'b0, 1'b0, 1'b0},
    // zero length, bad check byte a
    '{SYNC_FIRST, 1'b0, 1'b0, 1'b0}, '{SYNC_SECOND, 1'b0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b0, 1'b0},
    // sync broken by an arbitrary byte
    '{SYNC_FIRST, 1'b0, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0, 1'b0},
    // two-byte payload with extreme values, sums wrap
    '{SYNC_FIRST, 1'b0, 1'b0, 1'b0}, '{SYNC_SECOND, 1'b0, 1'b0, 1'b0},
    '{8'h02, 1'b0, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0, 1'b0},
    '{8'h01, 1'b0, 1'b0, 1'b0}, '{8'h04, 1'b0, 1'b0, 1'b0}
  };

  // shadow parser state
  phase_t     prd_phase = PH_HUNT;
  logic [7:0] prd_left  = 8'h00;
  logic [5:0] prd_pos   = 6'd0;
  logic [7:0] prd_sum_a = 8'h00;
  logic [7:0] prd_sum_b = 8'h00;
  logic [7:0] prd_ck_a  = 8'h00;
  logic [7:0] prd_rec [REC_BYTES] = '{default: 8'h00};

  gps_frame_t pending_fixes [$];
  int         items_sent   = 0;
  int         results_seen = 0;
  int         fails        = 0;
  int         cycles       = 0;
  int         stall_left   = 0;
  bit         quiet        = 1'b0;
  bit         calm         = 1'b0;

  function automatic gps_frame_t frame_from_bus(logic [REC_W-1:0] d, logic [1:0] u);
    gps_frame_t f;
    f.frame_ok     = u[0];
    f.fix_3d       = u[1];
    f.latitude     = d[31:0];
    f.longitude    = d[63:32];
    f.altitude     = d[95:64];
    f.ground_speed = d[127:96];
    f.course       = d[159:128];
    f.satellites   = d[167:160];
    f.fix_kind     = d[175:168];
    f.date_word    = d[207:176];
    f.time_word    = d[239:208];
    f.hdop_raw     = d[255:240];
    return f;
  endfunction

  // one byte through the shadow parser; returns 1 when it closes a frame
  function automatic bit decode_rx_byte(logic [7:0] b, output gps_frame_t res);
    logic [REC_W-1:0] rec_vec;
    bit               made;
    made = 1'b0;
    res  = frame_from_bus('0, 2'b00);
    case (prd_phase)
      PH_SYNC2: begin
        if (b == SYNC_SECOND) begin
          prd_pos   = 6'd0;
          prd_phase = PH_LEN;
        end else begin
          prd_phase = PH_HUNT;
        end
      end
      PH_LEN: begin
        prd_left  = b;
        prd_sum_a = b;
        prd_sum_b = b;
        prd_phase = PH_DATA;
      end
      PH_DATA: begin
        if (prd_left != 8'h00) begin
          // past the record the byte still counts in the sums
          if (prd_pos < REC_BYTES) begin
            prd_rec[prd_pos] = b;
            prd_pos          = prd_pos + 6'd1;
          end
          prd_left  = prd_left - 8'h01;
          prd_sum_a = prd_sum_a + b;
          prd_sum_b = prd_sum_b + prd_sum_a;
        end else begin
          prd_ck_a  = b;
          prd_phase = PH_CKB;
        end
      end
      PH_CKB: begin
        for (int i = 0; i < REC_BYTES; i++) rec_vec[8*i +: 8] = prd_rec[i];
        res = frame_from_bus(rec_vec, {prd_rec[FIX_KIND_POS] == FIX_3D_CODE,
                                       prd_ck_a == prd_sum_a && b == prd_sum_b});
        made      = 1'b1;
        prd_phase = PH_HUNT;
      end
      default: prd_phase = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
    endcase
    return made;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(logic [7:0] b, output bit made);
    gps_frame_t res;
    if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    made = decode_rx_byte(b, res);
    if (made) pending_fixes.push_back(res);
    @(negedge clk);
  endtask

  task automatic send_frame();
    logic [7:0] body [$];
    logic [7:0] len;
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    logic [7:0] b;
    int         kind;
    bit         made;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // line noise, never 0xdd so it cannot lock onto a header, ends hunting
      repeat ($urandom_range(1, 6)) begin
        b = ($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom_range(0, 255));
        if (b == SYNC_SECOND) b = 8'h00;
        send_byte(b, made);
      end
      send_byte(8'h00, made);
    end else if (kind == 1) begin
      b = $urandom_range(0, 1) ? SYNC_FIRST : 8'($urandom_range(0, 255));
      if (b == SYNC_SECOND) b = SYNC_FIRST;
      send_byte(SYNC_FIRST, made);
      send_byte(b, made);
    end else begin
      case ($urandom_range(0, 15))
        0:             len = 8'h00;
        1:             len = 8'(REC_BYTES);
        2:             len = 8'($urandom_range(33, 40));
        3:             len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(41, 255))
                                                         : 8'($urandom_range(1, 21));
        4, 5, 6, 7, 8: len = 8'($urandom_range(22, 32));
        default:       len = 8'($urandom_range(1, 31));
      endcase
      ck_a = len;
      ck_b = len;
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom_range(0, 255));
        if (i == FIX_KIND_POS && $urandom_range(0, 1) == 1) b = FIX_3D_CODE;
        body.push_back(b);
        ck_a = ck_a + b;
        ck_b = ck_b + ck_a;
      end
      case ($urandom_range(0, 9))
        0:       ck_a = ck_a ^ 8'($urandom_range(1, 255));
        1:       ck_b = ck_b ^ 8'($urandom_range(1, 255));
        default: ;
      endcase
      send_byte(SYNC_FIRST, made);
      send_byte(SYNC_SECOND, made);
      send_byte(len, made);
      foreach (body[i]) send_byte(body[i], made);
      send_byte(ck_a, made);
      send_byte(ck_b, made);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending_fixes.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else begin
      out_tready = 1'b1;
      if (!quiet && !calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 15);
    end
  end

  always @(posedge clk) begin : out_monitor
    gps_frame_t want;
    gps_frame_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = frame_from_bus(out_tdata, out_tuser);
      if (pending_fixes.size() == 0) begin
        $error("frame result with none expected: tuser %0h tdata %0h", out_tuser, out_tdata);
        fails++;
      end else begin
        want = pending_fixes.pop_front();
        results_seen++;
        check_field("frame_ok", 32'(want.frame_ok), 32'(got.frame_ok));
        check_field("fix_3d", 32'(want.fix_3d), 32'(got.fix_3d));
        check_field("latitude", want.latitude, got.latitude);
        check_field("longitude", want.longitude, got.longitude);
        check_field("altitude", want.altitude, got.altitude);
        check_field("ground_speed", want.ground_speed, got.ground_speed);
        check_field("course", want.course, got.course);
        check_field("satellites", 32'(want.satellites), 32'(got.satellites));
        check_field("fix_kind", 32'(want.fix_kind), 32'(got.fix_kind));
        check_field("date_word", want.date_word, got.date_word);
        check_field("time_word", want.time_word, got.time_word);
        check_field("hdop_raw", 32'(want.hdop_raw), 32'(got.hdop_raw));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    bit made;
    bit paused;
    paused = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(dir_tab[i].b, made);
      if (made && dir_tab[i].typed)
        pending_fixes[pending_fixes.size()-1] =
          frame_from_bus('0, {dir_tab[i].fix, dir_tab[i].ok});
    end
    wait_drained();

    while (items_sent < 1030) begin
      // hold the sender once until the parser has handed everything over
      if (!paused && items_sent >= 500) begin
        wait_drained();
        paused = 1'b1;
      end
      quiet = (items_sent >= 940);
      calm  = ($urandom_range(0, 3) == 0);
      send_frame();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
